// ===== hw/rtl/sky_gradient_sun_shader_macros.svh =====
// Assertion macros for the sky gradient sun shader.
// Used by the top level only; the macros expect signals named clk and rst in scope.
`ifndef SKY_GRADIENT_SUN_SHADER_MACROS_SVH
`define SKY_GRADIENT_SUN_SHADER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SGSS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define SGSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/sgss_pkg.sv =====
// Shared types and constants for the sky gradient sun shader.
// No dependencies; imported by every module of the block.
package sgss_pkg;

  localparam int NUM_STAGES = 6;
  localparam int CHAN_W     = 16;
  localparam int COMP_W     = 16;
  localparam int RGB_W      = 3 * CHAN_W;
  localparam int SCALE_W    = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_ZENITH_RGB     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HORIZON_RGB    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GROUND_RGB     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SUN_ENABLE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SUN_RGB        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SUN_DIR_XYZ    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SUN_COS_RADIUS = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SUN_EDGE_SCALE = 3'd7;

  localparam logic signed [COMP_W-1:0] COS_RADIUS_RESET = 16'sd16384;

  typedef struct packed {
    logic signed [COMP_W-1:0] dir_z;
    logic signed [COMP_W-1:0] dir_y;
    logic signed [COMP_W-1:0] dir_x;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } out_item_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
    logic [NUM_STAGES-1:0] valid;
  } pipe_ctrl_t;

  // One 16-bit field of a packed three-field word, field 0 in the low bits.
  function automatic logic [CHAN_W-1:0] chan(input logic [RGB_W-1:0] packed_word,
                                             input int unsigned idx);
    return packed_word[idx*CHAN_W +: CHAN_W];
  endfunction

endpackage

// ===== hw/rtl/sgss_pipe_ctrl.sv =====
// Valid tracking and per-stage advance logic for the shader pipeline.
// Depends on sgss_pkg.
module sgss_pipe_ctrl import sgss_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       out_ready,
  output logic       in_ready,
  output pipe_ctrl_t ctrl
);

  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES:0]   adv;

  // A stage may take new data when it is empty or when its content moves on.
  always_comb begin
    adv[NUM_STAGES] = out_ready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign in_ready   = adv[0];
  assign ctrl.load  = adv[NUM_STAGES-1:0];
  assign ctrl.valid = vld;

endmodule

// ===== hw/rtl/sgss_lerp_lane.sv =====
// One color channel blend a + (b - a) * t, rounded half up, over two register stages.
// Depends on sgss_pkg.
module sgss_lerp_lane import sgss_pkg::*; #(
  parameter int FRAC = 14
) (
  input  logic              clk,
  input  logic              load_mul,
  input  logic              load_sum,
  input  logic [CHAN_W-1:0] a,
  input  logic [CHAN_W-1:0] b,
  input  logic [FRAC:0]     t,
  output logic [CHAN_W-1:0] res
);

  // 17-bit signed difference times an (FRAC+2)-bit signed weight.
  localparam int PW = CHAN_W + FRAC + 3;
  localparam int SW = PW - FRAC;
  localparam logic signed [PW-1:0] HALF = PW'(1) << (FRAC - 1);

  logic signed [CHAN_W:0] diff;
  logic signed [PW-1:0]   prod;
  logic signed [PW-1:0]   prod_q;
  logic [CHAN_W-1:0]      a_q;
  logic signed [PW-1:0]   rnd;
  logic [SW-1:0]          sum;

  assign diff = $signed({1'b0, b}) - $signed({1'b0, a});
  assign prod = diff * $signed({1'b0, t});

  always_ff @(posedge clk) begin
    if (load_mul) begin
      a_q    <= a;
      prod_q <= prod;
    end
  end

  // The upper bits of the rounded product are its arithmetic shift by FRAC.
  assign rnd = prod_q + HALF;
  assign sum = {{(SW-CHAN_W){1'b0}}, a_q} + rnd[PW-1:FRAC];

  always_ff @(posedge clk) begin
    if (load_sum) begin
      res <= sum[CHAN_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/sgss_sun_weight.sv =====
// Sun disc weight: dot product, excess over the cosine radius, scaled and saturated.
// Four register stages; depends on sgss_pkg.
module sgss_sun_weight import sgss_pkg::*; #(
  parameter int FRAC = 14
) (
  input  logic                     clk,
  input  logic [3:0]               load,
  input  in_item_t                 dir,
  input  logic [RGB_W-1:0]         sun_dir_xyz,
  input  logic signed [COMP_W-1:0] sun_cos_radius,
  input  logic [SCALE_W-1:0]       sun_edge_scale,
  input  logic                     sun_enable,
  output logic [FRAC:0]            w
);

  localparam int PRW  = 2 * COMP_W;
  localparam int DOTW = PRW + 2;
  localparam int CSW  = COMP_W + FRAC;
  localparam int EXW  = ((DOTW > CSW) ? DOTW : CSW) + 1;
  localparam int MW   = EXW - 1;
  localparam int LOW  = (MW + 1) / 2;
  localparam int HIW  = MW - LOW;
  localparam int PW   = MW + SCALE_W + 1;
  localparam int WRW  = PW - FRAC - 8;
  localparam logic [PW-1:0]  HALF  = PW'(1) << (FRAC + 7);
  localparam logic [WRW-1:0] ONE_W = WRW'(1) << FRAC;

  logic signed [PRW-1:0]  prod_q [3];
  logic signed [COMP_W-1:0] comp [3];
  logic signed [EXW-1:0]  dot;
  logic signed [EXW-1:0]  cos_sh;
  logic signed [EXW-1:0]  excess;
  logic                   pos;
  logic [MW-1:0]          mag_q;
  logic [LOW+SCALE_W-1:0] pp_lo_q;
  logic [HIW+SCALE_W-1:0] pp_hi_q;
  logic [PW-1:0]          total;
  logic [WRW-1:0]         wr;

  assign comp[0] = dir.dir_x;
  assign comp[1] = dir.dir_y;
  assign comp[2] = dir.dir_z;

  // Stage 1: the three component products.
  always_ff @(posedge clk) begin
    if (load[0]) begin
      for (int i = 0; i < 3; i++) begin
        prod_q[i] <= comp[i] * $signed(chan(sun_dir_xyz, i));
      end
    end
  end

  // Stage 2: dot product and excess; a non-positive excess or a disabled sun zeroes it.
  assign dot = EXW'(prod_q[0]) + EXW'(prod_q[1]) + EXW'(prod_q[2]);
  assign cos_sh = EXW'(sun_cos_radius) <<< FRAC;
  assign excess = dot - cos_sh;
  assign pos = sun_enable && !excess[EXW-1] && (|excess);

  always_ff @(posedge clk) begin
    if (load[1]) begin
      mag_q <= pos ? excess[MW-1:0] : '0;
    end
  end

  // Stage 3: the wide product split into two partial products.
  always_ff @(posedge clk) begin
    if (load[2]) begin
      pp_lo_q <= mag_q[LOW-1:0] * sun_edge_scale;
      pp_hi_q <= mag_q[MW-1:LOW] * sun_edge_scale;
    end
  end

  // Stage 4: recombine, round, and saturate to one.
  assign total = {{(PW-HIW-SCALE_W-LOW){1'b0}}, pp_hi_q, {LOW{1'b0}}}
               + {{(PW-LOW-SCALE_W){1'b0}}, pp_lo_q} + HALF;
  assign wr = total[PW-1:FRAC+8];

  always_ff @(posedge clk) begin
    if (load[3]) begin
      w <= (wr > ONE_W) ? ONE_W[FRAC:0] : wr[FRAC:0];
    end
  end

endmodule

// ===== hw/rtl/sky_gradient_sun_shader.sv =====
// Top level of the sky gradient sun shader: configuration registers, pipeline, color path.
// Depends on sgss_pkg, sgss_pipe_ctrl, sgss_lerp_lane, sgss_sun_weight and the macro header.
//
//   Channel   Signals                           Moves
//   input     in_valid, in_ready, in_data       one view direction per transfer
//   output    out_valid, out_ready, out_data    one RGB sky color per transfer
//   config    cfg_write, cfg_index, cfg_data    one register write per enabled cycle
//
// One item can enter every cycle while the output is not stalled. The pipeline has six
// register stages: weight, color blend (two stages), sun weight scaling, and the sun blend
// (two stages).
// Reset clears the stage valid bits and sets the configuration registers to their defaults.
// A stalled output only holds the stages that are full behind it; empty stages keep filling.
`include "sky_gradient_sun_shader_macros.svh"

module sky_gradient_sun_shader import sgss_pkg::*; #(
  parameter int DIR_FRAC_BITS = 14
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int FRAC = DIR_FRAC_BITS;
  // Wide enough to hold y + 1 in Q.FRAC without overflow.
  localparam int EW = ((FRAC + 1 > COMP_W) ? FRAC + 1 : COMP_W) + 2;
  localparam logic signed [EW-1:0] ONE_E = EW'(1) << FRAC;
  localparam logic [FRAC:0] ONE_T = (FRAC + 1)'(1) << FRAC;

  // Configuration registers. Writes must arrive only while the pipeline is empty; unchecked.
  logic [RGB_W-1:0]         zenith_rgb;
  logic [RGB_W-1:0]         horizon_rgb;
  logic [RGB_W-1:0]         ground_rgb;
  logic                     sun_enable;
  logic [RGB_W-1:0]         sun_rgb;
  logic [RGB_W-1:0]         sun_dir_xyz;
  logic signed [COMP_W-1:0] sun_cos_radius;
  logic [SCALE_W-1:0]       sun_edge_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      zenith_rgb     <= '0;
      horizon_rgb    <= '0;
      ground_rgb     <= '0;
      sun_enable     <= 1'b0;
      sun_rgb        <= '0;
      sun_dir_xyz    <= '0;
      sun_cos_radius <= COS_RADIUS_RESET;
      sun_edge_scale <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ZENITH_RGB:     zenith_rgb     <= cfg_data[RGB_W-1:0];
        REG_HORIZON_RGB:    horizon_rgb    <= cfg_data[RGB_W-1:0];
        REG_GROUND_RGB:     ground_rgb     <= cfg_data[RGB_W-1:0];
        REG_SUN_ENABLE:     sun_enable     <= cfg_data[0];
        REG_SUN_RGB:        sun_rgb        <= cfg_data[RGB_W-1:0];
        REG_SUN_DIR_XYZ:    sun_dir_xyz    <= cfg_data[RGB_W-1:0];
        REG_SUN_COS_RADIUS: sun_cos_radius <= cfg_data[COMP_W-1:0];
        REG_SUN_EDGE_SCALE: sun_edge_scale <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: one valid bit per stage and a ready chain running backward.
  pipe_ctrl_t ctrl;

  sgss_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .ctrl      (ctrl)
  );

  assign out_valid = ctrl.valid[NUM_STAGES-1];

  // Stage 1: the up component selects the gradient half and gives its weight.
  // Above the horizon the weight is y clamped to one and the blend runs horizon to zenith.
  // At or below it the weight is y + 1 clamped at zero and the blend runs ground to horizon,
  // so a direction exactly on the horizon gives the horizon color.
  logic signed [EW-1:0] y_e;
  logic signed [EW-1:0] t_e;
  logic                 upper;
  logic                 upper_s1;
  logic [FRAC:0]        t_s1;

  assign y_e   = EW'(in_data.dir_y);
  assign upper = !in_data.dir_y[COMP_W-1] && (|in_data.dir_y);

  always_comb begin
    if (upper) begin
      t_e = (y_e > ONE_E) ? ONE_E : y_e;
    end else begin
      t_e = y_e + ONE_E;
      if (t_e[EW-1]) begin
        t_e = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[0]) begin
      upper_s1 <= upper;
      t_s1     <= t_e[FRAC:0];
    end
  end

  // Sun weight, stages 1 to 4. It is zero when the sun is off or the view misses the disc.
  logic [FRAC:0] sun_w;

  sgss_sun_weight #(
    .FRAC (FRAC)
  ) u_sun (
    .clk            (clk),
    .load           (ctrl.load[3:0]),
    .dir            (in_data),
    .sun_dir_xyz    (sun_dir_xyz),
    .sun_cos_radius (sun_cos_radius),
    .sun_edge_scale (sun_edge_scale),
    .sun_enable     (sun_enable),
    .w              (sun_w)
  );

  // Stages 2 and 3 blend the gradient; stage 4 holds the color beside the sun weight;
  // stages 5 and 6 blend toward the sun color. A zero sun weight leaves the color unchanged.
  logic [CHAN_W-1:0] grad_s3 [3];
  logic [CHAN_W-1:0] grad_s4 [3];
  logic [CHAN_W-1:0] final_c [3];

  for (genvar g = 0; g < 3; g++) begin : g_chan
    sgss_lerp_lane #(
      .FRAC (FRAC)
    ) u_grad (
      .clk      (clk),
      .load_mul (ctrl.load[1]),
      .load_sum (ctrl.load[2]),
      .a        (upper_s1 ? chan(horizon_rgb, g) : chan(ground_rgb, g)),
      .b        (upper_s1 ? chan(zenith_rgb, g) : chan(horizon_rgb, g)),
      .t        (t_s1),
      .res      (grad_s3[g])
    );

    always_ff @(posedge clk) begin
      if (ctrl.load[3]) begin
        grad_s4[g] <= grad_s3[g];
      end
    end

    sgss_lerp_lane #(
      .FRAC (FRAC)
    ) u_sun_mix (
      .clk      (clk),
      .load_mul (ctrl.load[4]),
      .load_sum (ctrl.load[5]),
      .a        (grad_s4[g]),
      .b        (chan(sun_rgb, g)),
      .t        (sun_w),
      .res      (final_c[g])
    );
  end

  // Blends of in-range channels stay in range, so the result needs no further clamp.
  assign out_data.red   = final_c[0];
  assign out_data.green = final_c[1];
  assign out_data.blue  = final_c[2];

  // The input side only stalls when the output holds a result nobody takes.
  `SGSS_ASSERT_IMPL(a_stall_from_output, !in_ready, out_valid && !out_ready,
                    "input stalled without output backpressure")
  // The sun weight never exceeds one once it carries an item.
  `SGSS_ASSERT_IMPL(a_sun_weight_range, ctrl.valid[3], sun_w <= ONE_T,
                    "sun weight above one")
  // Draining the last stage with the stage before it empty leaves the output empty.
  `SGSS_ASSERT_NEXT(a_output_drains, out_valid && out_ready && !ctrl.valid[NUM_STAGES-2],
                    !out_valid, "result repeated after transfer")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the sky gradient sun shader: a color scoreboard predicts every
// result from its own copy of the registers; tasks and a receiver drive the three channels.
// Depends on sgss_pkg and the sky_gradient_sun_shader RTL; needs no other file.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sgss_pkg::*;

  localparam int DIR_FRAC = 14;
  localparam logic [63:0] UNIT = 64'd1 << DIR_FRAC;
  localparam int RESET_CYCLES = 11;
  localparam int NUM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 300;
  localparam int HOLD_PHASE = 4;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LOW_IDLE_PCT = 34;
  localparam int HIGH_IDLE_PCT = 64;

  // One full set of register values, kept so that random directions can aim at the sun.
  typedef struct {
    logic [RGB_W-1:0]         zenith;
    logic [RGB_W-1:0]         horizon;
    logic [RGB_W-1:0]         ground;
    logic                     sun_on;
    logic [RGB_W-1:0]         sun_color;
    logic [RGB_W-1:0]         sun_dir;
    logic [COMP_W-1:0]        cos_radius;
    logic [SCALE_W-1:0]       edge_scale;
  } sky_setting_t;

  // The scoreboard holds its own copy of the registers, turns every accepted direction into
  // the color it must produce, and compares each color transfer with the oldest prediction.
  class sky_color_scoreboard;
    logic [RGB_W-1:0]         zenith;
    logic [RGB_W-1:0]         horizon;
    logic [RGB_W-1:0]         ground;
    logic                     sun_on;
    logic [RGB_W-1:0]         sun_color;
    logic [RGB_W-1:0]         sun_dir;
    logic signed [COMP_W-1:0] cos_radius;
    logic [SCALE_W-1:0]       edge_scale;
    out_item_t                expected_colors[$];
    int                       mismatches;

    function new();
      zenith     = '0;
      horizon    = '0;
      ground     = '0;
      sun_on     = 1'b0;
      sun_color  = '0;
      sun_dir    = '0;
      cos_radius = COS_RADIUS_RESET;
      edge_scale = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_ZENITH_RGB:     zenith     = data[RGB_W-1:0];
        REG_HORIZON_RGB:    horizon    = data[RGB_W-1:0];
        REG_GROUND_RGB:     ground     = data[RGB_W-1:0];
        REG_SUN_ENABLE:     sun_on     = data[0];
        REG_SUN_RGB:        sun_color  = data[RGB_W-1:0];
        REG_SUN_DIR_XYZ:    sun_dir    = data[RGB_W-1:0];
        REG_SUN_COS_RADIUS: cos_radius = data[COMP_W-1:0];
        REG_SUN_EDGE_SCALE: edge_scale = data[SCALE_W-1:0];
        default: ;
      endcase
    endfunction

    // Weighted blend with weight t in Q.14, rounded half up; always between a and b.
    function logic [CHAN_W-1:0] mix_channel(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b,
                                            logic [DIR_FRAC:0] t);
      logic [63:0] acc;
      acc = 64'(a) * (UNIT - 64'(t)) + 64'(b) * 64'(t) + (UNIT >> 1);
      return acc[DIR_FRAC +: CHAN_W];
    endfunction

    function out_item_t shade(in_item_t d);
      longint            y;
      longint            wt;
      longint            dot;
      longint            excess;
      logic [RGB_W-1:0]  lo_c;
      logic [RGB_W-1:0]  hi_c;
      logic [CHAN_W-1:0] col [3];
      logic [63:0]       sun_w;
      out_item_t         res;
      y = longint'(d.dir_y);
      // The horizon itself belongs to the lower half, where it is the full-weight end.
      if (y > 0) begin
        wt   = (y > longint'(UNIT)) ? longint'(UNIT) : y;
        lo_c = horizon;
        hi_c = zenith;
      end else begin
        wt   = y + longint'(UNIT);
        if (wt < 0) wt = 0;
        lo_c = ground;
        hi_c = horizon;
      end
      for (int i = 0; i < 3; i++)
        col[i] = mix_channel(lo_c[i*CHAN_W +: CHAN_W], hi_c[i*CHAN_W +: CHAN_W], wt[DIR_FRAC:0]);
      if (sun_on) begin
        dot = longint'(d.dir_x) * longint'($signed(sun_dir[15:0]))
            + longint'(d.dir_y) * longint'($signed(sun_dir[31:16]))
            + longint'(d.dir_z) * longint'($signed(sun_dir[47:32]));
        excess = dot - longint'(cos_radius) * longint'(UNIT);
        // Only a direction strictly inside the disc picks up any sun color.
        if (excess > 0) begin
          sun_w = (64'(excess) * 64'(edge_scale) + (UNIT << 7)) >> (DIR_FRAC + 8);
          if (sun_w > UNIT) sun_w = UNIT;
          for (int i = 0; i < 3; i++)
            col[i] = mix_channel(col[i], sun_color[i*CHAN_W +: CHAN_W], sun_w[DIR_FRAC:0]);
        end
      end
      res.red   = col[0];
      res.green = col[1];
      res.blue  = col[2];
      return res;
    endfunction

    function void note_direction(in_item_t d);
      expected_colors.insert(expected_colors.size(), shade(d));
    endfunction

    function void compare_channel(string name, logic [CHAN_W-1:0] want, logic [CHAN_W-1:0] got);
      if (got !== want) begin
        $display("%0t %s mismatch: expected %h, got %h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_color(out_item_t got);
      out_item_t want;
      if (expected_colors.size() == 0) begin
        $display("%0t unexpected color transfer: expected none, got %h", $time, got);
        mismatches++;
        return;
      end
      want = expected_colors.pop_front();
      compare_channel("red", want.red, got.red);
      compare_channel("green", want.green, got.green);
      compare_channel("blue", want.blue, got.blue);
    endfunction

    function int pending();
      return expected_colors.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sky_color_scoreboard colors_sb;
  sky_setting_t        cur_setting;
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  bit                  hold_pending = 1'b0;
  int                  quiet_cycles = 0;

  sky_gradient_sun_shader u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Both channels are sampled at the clock edge, where every signal still holds the value it
  // had before the edge, so a transfer is seen exactly once no matter how the step is ordered.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) colors_sb.note_direction(in_data);
      if (out_valid && out_ready) colors_sb.check_color(out_data);
    end
  end

  // The watchdog ends a hung run: it counts edges at which no transfer and no register write
  // happens, which covers a stuck input, a lost result and the long output hold-off alike.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("sky_gradient_sun_shader verification failed");
      $finish;
    end
  end

  // The receiver drops out_ready at random at the current idle rate. When asked, it instead
  // holds off for a long stretch that it counts itself, so that the pipeline fills up and the
  // block has to stall its input while the sender keeps offering directions.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (rst) begin
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  function automatic in_item_t mk_dir(int x, int y, int z);
    in_item_t d;
    d.dir_x = 16'(x);
    d.dir_y = 16'(y);
    d.dir_z = 16'(z);
    return d;
  endfunction

  // Random directions: many aim close to the sun so that the partial disc edge is reached,
  // the rest are unit-range vectors, raw bit patterns, and the special heights.
  function automatic in_item_t random_dir();
    int          x;
    int          y;
    int          z;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      x = int'($signed(cur_setting.sun_dir[15:0])) + int'($urandom_range(0, 800)) - 400;
      y = int'($signed(cur_setting.sun_dir[31:16])) + int'($urandom_range(0, 800)) - 400;
      z = int'($signed(cur_setting.sun_dir[47:32])) + int'($urandom_range(0, 800)) - 400;
    end else if (roll < 70) begin
      x = int'($urandom_range(0, 32768)) - 16384;
      y = int'($urandom_range(0, 32768)) - 16384;
      z = int'($urandom_range(0, 32768)) - 16384;
    end else if (roll < 85) begin
      x = $urandom;
      y = $urandom;
      z = $urandom;
    end else begin
      x = int'($urandom_range(0, 4000)) - 2000;
      z = int'($urandom_range(0, 4000)) - 2000;
      case ($urandom_range(0, 6))
        0: y = 0;
        1: y = 1;
        2: y = -1;
        3: y = 16384;
        4: y = -16384;
        5: y = 32767;
        default: y = -32768;
      endcase
    end
    return mk_dir(x, y, z);
  endfunction

  // The first two phases use the register extremes; the others draw a plausible sky.
  function automatic sky_setting_t pick_setting(int ph);
    sky_setting_t s;
    s.zenith     = 48'({$urandom, $urandom});
    s.horizon    = 48'({$urandom, $urandom});
    s.ground     = 48'({$urandom, $urandom});
    s.sun_on     = ($urandom_range(0, 3) != 0);
    s.sun_color  = 48'({$urandom, $urandom});
    s.sun_dir    = {16'(int'($urandom_range(0, 12000)) - 6000),
                    16'($urandom_range(9000, 16384)),
                    16'(int'($urandom_range(0, 12000)) - 6000)};
    s.cos_radius = 16'($urandom_range(13000, 16383));
    s.edge_scale = 24'($urandom_range(256, 65536));
    if (ph == 0) begin
      s.zenith     = '1;
      s.horizon    = '0;
      s.ground     = '1;
      s.sun_on     = 1'b1;
      s.sun_color  = '1;
      s.sun_dir    = {3{16'h8000}};
      s.cos_radius = 16'hC000;
      s.edge_scale = '1;
    end else if (ph == 1) begin
      s.zenith     = '0;
      s.horizon    = '1;
      s.ground     = '0;
      s.sun_on     = 1'b1;
      s.sun_color  = '0;
      s.sun_dir    = {3{16'h7FFF}};
      s.cos_radius = COS_RADIUS_RESET;
      s.edge_scale = '1;
    end else if (ph == 2) begin
      s.sun_on = 1'b0;
    end else if (ph == HOLD_PHASE) begin
      s.sun_on = 1'b1;
    end
    return s;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    colors_sb.write_reg(idx, data);
  endtask

  // Writes all eight registers back to back. Narrow registers get random upper data bits,
  // which the block has to drop.
  task automatic apply_setting(input sky_setting_t s);
    write_reg(REG_ZENITH_RGB, s.zenith);
    write_reg(REG_HORIZON_RGB, s.horizon);
    write_reg(REG_GROUND_RGB, s.ground);
    write_reg(REG_SUN_ENABLE, {47'({$urandom, $urandom}), s.sun_on});
    write_reg(REG_SUN_RGB, s.sun_color);
    write_reg(REG_SUN_DIR_XYZ, s.sun_dir);
    write_reg(REG_SUN_COS_RADIUS, {32'($urandom), s.cos_radius});
    write_reg(REG_SUN_EDGE_SCALE, {24'($urandom), s.edge_scale});
    cfg_write <= 1'b0;
    cur_setting = s;
  endtask

  // Offers one direction after a random gap and holds it until the transfer happens. A
  // direction that follows without a gap keeps in_valid high, so it is never lowered and
  // raised within one step.
  task automatic send_dir(input in_item_t d);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stops offering and waits until every predicted color has come back. The first edge is
  // always waited for, so the last transfer has been noted before the count is read.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (colors_sb.pending() != 0);
  endtask

  initial begin : stimulus
    sky_setting_t s;
    colors_sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // With the reset values every color is black and the sun is off.
    send_dir(mk_dir(0, 16384, 0));
    send_dir(mk_dir(0, -16384, 0));
    drain();

    // A sun straight overhead with a small disc and a realistic edge scale.
    s.zenith     = {16'h1800, 16'h0C00, 16'h0400};
    s.horizon    = {16'h0E00, 16'h0D00, 16'h0C00};
    s.ground     = {16'h0200, 16'h0300, 16'h0500};
    s.sun_on     = 1'b1;
    s.sun_color  = {16'h8000, 16'hE000, 16'hFFFF};
    s.sun_dir    = {16'sd0, 16'sd16384, 16'sd0};
    s.cos_radius = 16'sd16220;
    s.edge_scale = 24'd25600;
    apply_setting(s);
    send_dir(mk_dir(0, 0, 0));             // exactly on the horizon
    send_dir(mk_dir(16384, 0, 0));
    send_dir(mk_dir(0, 16384, 0));         // sun center, weight saturates
    send_dir(mk_dir(0, 16300, 0));         // inside the disc edge
    send_dir(mk_dir(0, 16220, 0));         // exactly on the disc rim
    send_dir(mk_dir(0, 16221, 0));         // just inside the rim
    send_dir(mk_dir(0, -16384, 0));
    send_dir(mk_dir(0, -8192, 0));
    send_dir(mk_dir(0, 8192, 0));
    send_dir(mk_dir(0, 1, 0));
    send_dir(mk_dir(0, -1, 0));
    send_dir(mk_dir(0, 32767, 0));         // out of range upward
    send_dir(mk_dir(0, -32768, 0));        // out of range downward
    send_dir(mk_dir(32767, -32768, 32767));
    send_dir(mk_dir(-32768, 32767, -32768));
    send_dir(mk_dir(0, 16385, 0));
    send_dir(mk_dir(0, -16385, 0));
    drain();

    // A degenerate disc: a zero edge scale keeps the sun invisible even past the rim.
    s.cos_radius = COS_RADIUS_RESET;
    s.edge_scale = '0;
    apply_setting(s);
    send_dir(mk_dir(0, 16384, 0));
    send_dir(mk_dir(0, 32767, 0));
    drain();

    // Random phases: sender idles more lightly first, then the receiver, then neither.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      apply_setting(pick_setting(ph));
      if (ph < 2) begin
        send_idle_pct = LOW_IDLE_PCT;
        recv_idle_pct = HIGH_IDLE_PCT;
      end else if (ph < 4) begin
        send_idle_pct = HIGH_IDLE_PCT;
        recv_idle_pct = LOW_IDLE_PCT;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (ph == HOLD_PHASE) hold_pending = 1'b1;
      repeat (ITEMS_PER_PHASE) send_dir(random_dir());
      drain();
    end

    // Give a stray extra result time to show up before the verdict.
    repeat (NUM_STAGES + 4) @(posedge clk);
    if (colors_sb.pending() != 0) begin
      $display("%0t colors still outstanding: expected 0, got %0d", $time, colors_sb.pending());
      colors_sb.mismatches++;
    end
    if (colors_sb.mismatches == 0)
      $display("sky_gradient_sun_shader verification clean");
    else
      $display("sky_gradient_sun_shader verification failed");
    $finish;
  end

endmodule
